>>> rtl/core/thruster_ramp_generator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the thruster ramp generator
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef THRUSTER_RAMP_GENERATOR_ASSERT_SVH
`define THRUSTER_RAMP_GENERATOR_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define TRG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("thruster ramp generator: assertion failed");

// Same, with a caller-supplied message.
`define TRG_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

>>> rtl/core/trg_pkg.sv
// ---------------------------------------------------------------------------
// trg_pkg
// Shared widths, constants and types of the thruster ramp generator.
// ---------------------------------------------------------------------------
`default_nettype none

package trg_pkg;

  localparam int SpeedW   = 8;
  localparam int ChanW    = 6;
  localparam int HalfW    = 9;
  localparam int OpW      = 3;
  localparam int NumComp  = 7;
  localparam int SumW     = 11;   // holds 7 * [-128, 127]
  localparam int RegW     = 32;
  localparam int AddrW    = 3;

  // operation codes; anything above roll is dropped
  localparam logic [OpW-1:0] OpRoll = 3'd6;

  // register indexes (paddr[2])
  localparam logic RegRampStep     = 1'b0;
  localparam logic RegMotorChannel = 1'b1;

  localparam logic [SpeedW-1:0] RampStepReset = 8'd20;
  localparam logic [SpeedW-1:0] MinStep       = 8'd4;
  localparam logic [SpeedW-1:0] MaxDiff       = 8'd200;

  localparam logic signed [SumW-1:0]   SumMax   = 11'sd100;
  localparam logic signed [SumW-1:0]   SumMin   = -11'sd100;
  localparam logic signed [SpeedW-1:0] SpeedMax = 8'sd100;
  localparam logic signed [SpeedW-1:0] SpeedMin = -8'sd100;

  localparam logic [HalfW-1:0] MotorMidHalf = 9'd188;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // one ramp request from the front to the back
  typedef struct packed {
    logic signed [SpeedW-1:0] start;
    logic signed [SpeedW-1:0] target;
  } ramp_cmd_t;

  // queue head as seen by the back
  typedef struct packed {
    logic      valid;
    ramp_cmd_t cmd;
  } queue_head_t;

endpackage

`default_nettype wire

>>> rtl/core/trg_queue.sv
// ---------------------------------------------------------------------------
// trg_queue
// Short FIFO of ramp requests between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module trg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  trg_pkg::ramp_cmd_t  push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output trg_pkg::queue_head_t head_o
);
  import trg_pkg::*;

  ramp_cmd_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/trg_front.sv
// ---------------------------------------------------------------------------
// trg_front
// Accept speed updates, keep the seven components and a running sum,
// saturate the total and queue a ramp request.
// ---------------------------------------------------------------------------
`default_nettype none

module trg_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [trg_pkg::OpW-1:0]           operation_i,
  input  logic signed [trg_pkg::SpeedW-1:0] component_speed_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output trg_pkg::ramp_cmd_t                q_cmd_o
);
  import trg_pkg::*;

  logic signed [SpeedW-1:0] comp_q [NumComp];
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [SpeedW-1:0] prev_q;
  logic signed [SpeedW-1:0] total;
  logic                     accept, update;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  // drop codes past roll
  assign update     = accept && (operation_i <= OpRoll);

  // swap the old component out of the running sum
  always_comb begin
    sum_d = sum_q - SumW'(comp_q[operation_i]) + SumW'(component_speed_i);
    if (sum_d > SumMax) begin
      total = SpeedMax;
    end else if (sum_d < SumMin) begin
      total = SpeedMin;
    end else begin
      total = sum_d[SpeedW-1:0];
    end
  end

  assign q_push_o       = update;
  assign q_cmd_o.start  = prev_q;
  assign q_cmd_o.target = total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumComp; i++) begin
        comp_q[i] <= '0;
      end
      sum_q  <= '0;
      prev_q <= '0;
    end else if (update) begin
      comp_q[operation_i] <= component_speed_i;
      sum_q               <= sum_d;
      prev_q              <= total;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/trg_back.sv
// ---------------------------------------------------------------------------
// trg_back
// Walk one ramp request from start toward target in fixed steps and drive
// the registered result stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "thruster_ramp_generator_assert.svh"

module trg_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  trg_pkg::queue_head_t               head_i,
  output logic                               q_pop_o,
  input  logic [trg_pkg::SpeedW-1:0]         ramp_step_i,
  input  logic [trg_pkg::ChanW-1:0]          motor_channel_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [trg_pkg::ChanW-1:0]          channel_o,
  output logic signed [trg_pkg::SpeedW-1:0]  ramp_speed_o,
  output logic [trg_pkg::HalfW-1:0]          command_half_units_o,
  output logic                               last_o
);
  import trg_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e                   state_q, state_d;
  logic signed [SpeedW-1:0] cur_q, cur_d;
  logic signed [SpeedW-1:0] tgt_q, tgt_d;
  logic [SpeedW-1:0]        rem_q, rem_d;
  logic                     neg_q, neg_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [SpeedW-1:0] out_speed_q, out_speed_d;
  logic [HalfW-1:0]         out_half_q, out_half_d;
  logic [ChanW-1:0]         out_chan_q, out_chan_d;
  logic                     out_last_q, out_last_d;

  logic [SpeedW-1:0]        step;
  logic signed [SpeedW:0]   diff;
  logic signed [SpeedW:0]   cur_next;
  logic                     advance;
  logic                     take_step;

  assign step      = (ramp_step_i < MinStep) ? MinStep : ramp_step_i;
  assign diff      = (SpeedW + 1)'(head_i.cmd.target) - (SpeedW + 1)'(head_i.cmd.start);
  assign advance   = !out_valid_q || out_ready_i;
  assign take_step = (rem_q >= step);
  assign cur_next  = neg_q ? ((SpeedW + 1)'(cur_q) - $signed({1'b0, step}))
                           : ((SpeedW + 1)'(cur_q) + $signed({1'b0, step}));
  assign q_pop_o   = (state_q == StIdle) && head_i.valid;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_speed_d = out_speed_q;
    out_half_d  = out_half_q;
    out_chan_d  = out_chan_q;
    out_last_d  = out_last_q;
    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          cur_d   = head_i.cmd.start;
          tgt_d   = head_i.cmd.target;
          neg_d   = diff[SpeedW];
          rem_d   = diff[SpeedW] ? SpeedW'(-diff) : diff[SpeedW-1:0];
          state_d = StRun;
        end
      end
      StRun: begin
        if (advance) begin
          out_valid_d = 1'b1;
          out_chan_d  = motor_channel_i;
          if (take_step) begin
            out_speed_d = cur_q;
            out_half_d  = HalfW'(cur_q) + MotorMidHalf;
            out_last_d  = 1'b0;
            cur_d       = cur_next[SpeedW-1:0];
            rem_d       = rem_q - step;
          end else begin
            out_speed_d = tgt_q;
            out_half_d  = HalfW'(tgt_q) + MotorMidHalf;
            out_last_d  = 1'b1;
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    tgt_q       <= tgt_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    out_speed_q <= out_speed_d;
    out_half_q  <= out_half_d;
    out_chan_q  <= out_chan_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o          = out_valid_q;
  assign channel_o            = out_chan_q;
  assign ramp_speed_o         = out_speed_q;
  assign command_half_units_o = out_half_q;
  assign last_o               = out_last_q;

  `TRG_ASSERT(a_pop_only_idle, q_pop_o |-> (state_q == StIdle))
  `TRG_ASSERT(a_rem_bounded, (state_q == StRun) |-> (rem_q <= MaxDiff))
  `TRG_ASSERT_MSG(a_end_marks_last, (state_q == StRun && advance && !take_step) |=> (out_last_q && out_valid_q && state_q == StIdle), "ramp end without last")
  `TRG_ASSERT(a_cur_in_range, (state_q == StRun) |-> (cur_q <= SpeedMax && cur_q >= SpeedMin))

endmodule

`default_nettype wire

>>> rtl/core/thruster_ramp_generator.sv
// ---------------------------------------------------------------------------
// thruster_ramp_generator
// Slew-limited ramp toward the saturated sum of seven speed components,
// with an APB-style register port for step size and motor channel.
// ---------------------------------------------------------------------------
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+------------------------------
//   in        | sink      | in_valid_i/in_ready_o | operation_i, component_speed_i
//   out       | source    | out_valid_o/out_ready_i | channel_o, ramp_speed_o,
//             |           |                       | command_half_units_o, last_o
//   cfg       | sink      | psel/penable/pready   | paddr, pwdata, prdata
//
// Walker: a request is loaded, then each intermediate value is emitted,
//   then the final value; the number of intermediate values is
//   |new - old| / step, at most 50.
// The front takes a request while the queue has room; the
//   two-entry queue lets it run ahead of the walker.
// Reset: components, running sum and previous total clear to zero,
//   ramp_step to 20, motor_channel to 0; no clearing pass.
// Stalls: out_ready_i low with a result pending holds the result register
//   and the walker; a full queue drops in_ready_o.
// ---------------------------------------------------------------------------
`default_nettype none

module thruster_ramp_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input requests
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [trg_pkg::OpW-1:0]            operation_i,
  input  logic signed [trg_pkg::SpeedW-1:0]  component_speed_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [trg_pkg::ChanW-1:0]          channel_o,
  output logic signed [trg_pkg::SpeedW-1:0]  ramp_speed_o,
  output logic [trg_pkg::HalfW-1:0]          command_half_units_o,
  output logic                               last_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [trg_pkg::AddrW-1:0]          paddr,
  input  logic [trg_pkg::RegW-1:0]           pwdata,
  output logic [trg_pkg::RegW-1:0]           prdata,
  output logic                               pready
);
  import trg_pkg::*;

  logic [SpeedW-1:0] ramp_step_q;
  logic [ChanW-1:0]  motor_channel_q;
  logic              cfg_write;
  logic              reg_sel;

  logic              q_push, q_full, q_pop;
  ramp_cmd_t         q_cmd;
  queue_head_t       q_head;

  // Registers sit on 4-byte boundaries; paddr[2] picks the register.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q     <= RampStepReset;
      motor_channel_q <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        RegRampStep:     ramp_step_q     <= pwdata[SpeedW-1:0];
        RegMotorChannel: motor_channel_q <= pwdata[ChanW-1:0];
        default: begin
          ramp_step_q <= ramp_step_q;
        end
      endcase
    end
  end

  // Read back the selected register, zero-extended.
  always_comb begin
    case (reg_sel)
      RegRampStep:     prdata = RegW'(ramp_step_q);
      RegMotorChannel: prdata = RegW'(motor_channel_q);
      default:         prdata = '0;
    endcase
  end

  // Front: update components, saturate total, queue the ramp request.
  trg_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .component_speed_i (component_speed_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_cmd_o           (q_cmd)
  );

  // Decouple front and walker.
  trg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  // Back: step from old total to new, one value per cycle unless out stalls.
  trg_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_i               (q_head),
    .q_pop_o              (q_pop),
    .ramp_step_i          (ramp_step_q),
    .motor_channel_i      (motor_channel_q),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .channel_o            (channel_o),
    .ramp_speed_o         (ramp_speed_o),
    .command_half_units_o (command_half_units_o),
    .last_o               (last_o)
  );

endmodule

`default_nettype wire

>>> sim/thruster_ramp_generator_tb.sv
// ----------------------------------------------------------------------------
// thruster_ramp_generator_tb
// Self-checking bench for the thruster ramp generator. Send component
// updates through the request channel, predict every ramp point in a local
// model of the seven components and the last commanded total, and compare
// each accepted result against the oldest pending prediction. Step size and
// motor channel are reprogrammed over the register port between phases.
// ----------------------------------------------------------------------------

module thruster_ramp_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Component select codes as seen on operation_i; the top code is dropped.
  typedef enum logic [trg_pkg::OpW-1:0] {
    OpStrafe,
    OpForward,
    OpVertical,
    OpTurn,
    OpYaw,
    OpPitch,
    OpRoll,
    OpNone
  } comp_op_e;

  // One ramp point as it leaves the block.
  typedef struct packed {
    logic [trg_pkg::ChanW-1:0]  channel;
    logic [trg_pkg::SpeedW-1:0] speed;
    logic [trg_pkg::HalfW-1:0]  half_units;
    logic                       last;
  } ramp_point_t;

  // Cycles to let pass once the last result is in.
  localparam int SettleCycles = 64;
  // Length of the long receiver hold-off.
  localparam int HoldCycles   = 600;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                              clk_i             = 1'b0;
  logic                              rst_ni            = 1'b0;
  logic                              in_valid_i        = 1'b0;
  logic                              in_ready_o;
  logic [trg_pkg::OpW-1:0]           operation_i       = '0;
  logic signed [trg_pkg::SpeedW-1:0] component_speed_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i       = 1'b0;
  logic [trg_pkg::ChanW-1:0]         channel_o;
  logic signed [trg_pkg::SpeedW-1:0] ramp_speed_o;
  logic [trg_pkg::HalfW-1:0]         command_half_units_o;
  logic                              last_o;
  logic                              psel              = 1'b0;
  logic                              penable           = 1'b0;
  logic                              pwrite            = 1'b0;
  logic [trg_pkg::AddrW-1:0]         paddr             = '0;
  logic [trg_pkg::RegW-1:0]          pwdata            = '0;
  logic [trg_pkg::RegW-1:0]          prdata;
  logic                              pready;

  // --------------------------------------------------------------------------
  // Predictor state: a shadow of the components, the last total and the
  // two registers, updated at the edge that accepts each request or write.
  // --------------------------------------------------------------------------
  logic signed [trg_pkg::SpeedW-1:0] comp_speed [trg_pkg::NumComp];
  int                                last_total  = 0;
  logic [trg_pkg::SpeedW-1:0]        step_cfg    = trg_pkg::RampStepReset;
  logic [trg_pkg::ChanW-1:0]         chan_cfg    = '0;
  ramp_point_t                       expected_ramp [$];

  int mismatch_count = 0;

  // Idle rates in percent per cycle, and the hold-off trigger count.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;

  initial begin
    foreach (comp_speed[k]) comp_speed[k] = '0;
  end

  thruster_ramp_generator u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .operation_i          (operation_i),
    .component_speed_i    (component_speed_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .channel_o            (channel_o),
    .ramp_speed_o         (ramp_speed_o),
    .command_half_units_o (command_half_units_o),
    .last_o               (last_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // 50 MHz clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: well beyond the slowest legal run.
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Queue one ramp point, tagging it with the current channel.
  function automatic void add_point(int value, logic fin);
    ramp_point_t pt;
    int          half;
    half          = value + int'(trg_pkg::MotorMidHalf);
    pt.channel    = chan_cfg;
    pt.speed      = value[7:0];
    pt.half_units = half[8:0];
    pt.last       = fin;
    expected_ramp.push_back(pt);
  endfunction

  // Update one component, saturate the new sum and walk from the old total
  // toward it in fixed strides; the exact target always closes the ramp.
  function automatic void predict_ramp(comp_op_e op, logic signed [7:0] spd);
    int total;
    int diff;
    int dir;
    int stride;
    int count;
    if (op == OpNone) return;
    comp_speed[op] = spd;
    total = 0;
    foreach (comp_speed[k]) total += comp_speed[k];
    if (total > int'(trg_pkg::SpeedMax)) total = int'(trg_pkg::SpeedMax);
    if (total < int'(trg_pkg::SpeedMin)) total = int'(trg_pkg::SpeedMin);
    diff = total - last_total;
    dir  = 1;
    if (diff < 0) begin
      dir  = -1;
      diff = -diff;
    end
    // Clamp tiny strides so a ramp never exceeds fifty intermediate points.
    stride = int'(step_cfg);
    if (stride < int'(trg_pkg::MinStep)) stride = int'(trg_pkg::MinStep);
    count = diff / stride;
    for (int i = 0; i < count; i++) add_point(last_total + i * stride * dir, 1'b0);
    add_point(total, 1'b1);
    last_total = total;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  task automatic flag_error(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", what);
  endtask

  // Receiver: stall at the current rate, or hold off completely for a long
  // stretch whenever a test bumps hold_requests.
  always @(posedge clk_i) begin : drive_out_ready
    int hold_left;
    int hold_served;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : check_ramp
    ramp_point_t seen;
    ramp_point_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = {channel_o, ramp_speed_o, command_half_units_o, last_o};
      if (expected_ramp.size() == 0) begin
        flag_error($sformatf("unexpected result ch=%0d spd=%0d half=%0d last=%0b",
                             seen.channel, $signed(seen.speed), seen.half_units,
                             seen.last));
      end else begin
        want = expected_ramp.pop_front();
        if (seen !== want) begin
          flag_error($sformatf({"ramp point: want ch=%0d spd=%0d half=%0d last=%0b,",
                                " got ch=%0d spd=%0d half=%0d last=%0b"},
                               want.channel, $signed(want.speed), want.half_units,
                               want.last, seen.channel, $signed(seen.speed),
                               seen.half_units, seen.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side and register port
  // --------------------------------------------------------------------------

  // Offer one request after a random gap; hold it until accepted, then
  // record its prediction at the accepting edge.
  task automatic send_item(comp_op_e op, logic signed [7:0] spd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    component_speed_i <= spd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_ramp(op, spd);
  endtask

  // Drop valid, wait for every pending result, then let the walker drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_ramp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup then access cycle; the register takes the data at the edge that
  // sees psel, penable, pwrite and pready all high, then goes idle.
  task automatic reg_write(logic idx, logic [trg_pkg::RegW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == trg_pkg::RegRampStep) step_cfg = value[7:0];
    else                             chan_cfg = value[5:0];
    @(posedge clk_i);
  endtask

  // Reprogram both registers with the block idle.
  task automatic configure(logic [31:0] step_word, logic [31:0] chan_word);
    settle();
    reg_write(trg_pkg::RegRampStep, step_word);
    reg_write(trg_pkg::RegMotorChannel, chan_word);
  endtask

  function automatic comp_op_e random_op();
    if ($urandom_range(19) == 0) return OpNone;
    return comp_op_e'($urandom_range(6, 0));
  endfunction

  // Mostly in-range speeds, with a share of full-scale and out-of-range
  // values so the total slams into both limits and ramps run long.
  function automatic logic signed [7:0] random_speed();
    int pick;
    int v;
    pick = $urandom_range(9);
    case (pick)
      0, 1: v = $urandom_range(255);
      2: begin
        v = $urandom_range(1) ? 100 : -100;
      end
      3: begin
        v = $urandom_range(1) ? 127 : -128;
      end
      4: v = 0;
      default: v = int'($urandom_range(200)) - 100;
    endcase
    return v[7:0];
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Touch every component once with reset registers, then the dropped code.
  task automatic test_operations();
    send_item(OpStrafe, 8'sd40);
    send_item(OpForward, -8'sd30);
    send_item(OpVertical, 8'sd25);
    send_item(OpTurn, -8'sd5);
    send_item(OpYaw, 8'sd12);
    send_item(OpPitch, -8'sd2);
    send_item(OpRoll, 8'sd60);
    send_item(OpNone, 8'sd127);
    send_item(OpNone, -8'sd128);
  endtask

  // Full-scale component values: saturate high with no change in total,
  // swing down, saturate low, then return components to zero.
  task automatic test_field_extremes();
    send_item(OpStrafe, 8'sd127);
    send_item(OpStrafe, -8'sd128);
    send_item(OpForward, -8'sd128);
    send_item(OpForward, 8'sd127);
    send_item(OpStrafe, 8'sd0);
    send_item(OpForward, 8'sd0);
  endtask

  // Stride handling: zero and three act as four, a stride wider than the
  // swing leaves only the final point, and a repeated total gives the same.
  task automatic test_step_settings();
    configure(32'd0, 32'd63);
    send_item(OpStrafe, -8'sd128);
    send_item(OpForward, -8'sd100);
    send_item(OpStrafe, 8'sd127);      // full swing, longest ramp
    configure(32'd3, 32'd63);
    send_item(OpStrafe, -8'sd128);
    configure(32'd255, 32'd21);
    send_item(OpStrafe, 8'sd127);
    configure(32'd200, 32'd42);
    send_item(OpStrafe, -8'sd128);
    // upper bits of the channel word must not leak into the result
    configure(32'd4, 32'hFFFF_FF80);
    send_item(OpStrafe, 8'sd0);
    send_item(OpStrafe, 8'sd0);
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int n_items,
                             int step_lo, int step_hi);
    configure($urandom_range(step_hi, step_lo), $urandom_range(63, 0));
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int k = 0; k < n_items; k++) send_item(random_op(), random_speed());
    settle();
  endtask

  // Hold the receiver off while big swings keep coming: the queue fills
  // and the request side must stall without losing anything.
  task automatic test_backpressure();
    configure(32'd10, 32'd17);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int k = 0; k < 12; k++) begin
      send_item(OpStrafe, (k % 2 == 0) ? 8'sd127 : -8'sd128);
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operations();
    test_field_extremes();
    test_step_settings();
    test_random(8, 83, 145, 4, 12);
    test_random(83, 8, 145, 13, 200);
    test_backpressure();
    test_random(0, 0, 145, 0, 255);

    settle();
    if (mismatch_count == 0 && expected_ramp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/trg_pkg.sv
rtl/core/trg_queue.sv
rtl/core/trg_front.sv
rtl/core/trg_back.sv
rtl/core/thruster_ramp_generator.sv
sim/thruster_ramp_generator_tb.sv
